### rtl/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared constants and types of the memory polynomial predistorter.
// ----------------------------------------------------------------------------
package mpp_pkg;

	localparam int MEMORY_DEPTH = 2;
	localparam int ORDER        = 2;
	localparam int SAMPLE_BITS  = 14;

	localparam int ROWS    = MEMORY_DEPTH + 1;
	localparam int POWERS  = ORDER + 1;
	localparam int CELLS   = ROWS * POWERS;
	localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int PIDX_W  = (POWERS > 1) ? $clog2(POWERS) : 1;
	localparam int CNT_W   = $clog2(CELLS + 1);

	localparam int COEFF_W = 24;
	localparam int BASIS_W = 32;
	localparam int LIMIT_W = 21;
	localparam int ACC_W   = 64;
	localparam int PROD_W  = COEFF_W + BASIS_W;

	localparam int COEFF_EPS = 131;
	localparam int COEFF_ONE = 65536;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(131072);

	// envelope scaling: (I*I+Q*Q) * 2^16 / AM^2
	localparam int ENV_SH  = 2 * (SAMPLE_BITS - 1) - 16;
	localparam int ENV_SHR = (ENV_SH > 0) ? ENV_SH : 0;
	localparam int ENV_SHL = (ENV_SH < 0) ? -ENV_SH : 0;
	localparam int PWR_W   = 2 * SAMPLE_BITS;
	localparam int ENV_W   = PWR_W - ENV_SHR + ENV_SHL;

	localparam int OUT_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int OUT_MIN = -(1 << (SAMPLE_BITS - 1));

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEFF  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENV,
		ST_BASIS,
		ST_LOAD,
		ST_SUM,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic signed [BASIS_W-1:0] bi;
		logic signed [BASIS_W-1:0] bq;
		logic signed [COEFF_W-1:0] cr;
		logic signed [COEFF_W-1:0] ci;
	} cell_data_t;

	typedef struct packed {
		logic rotate;
		logic load;
	} cell_ctl_t;

endpackage

### rtl/mpp_cell.sv
// ----------------------------------------------------------------------------
// mpp_cell
// One delay-line/coefficient cell; hands its contents to the next cell.
// ----------------------------------------------------------------------------
module mpp_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              first_cell,
	input  mpp_pkg::cell_ctl_t                ctl,
	input  mpp_pkg::cell_data_t               prev,
	input  logic                              coeff_we,
	input  logic signed [mpp_pkg::COEFF_W-1:0] wr_real,
	input  logic signed [mpp_pkg::COEFF_W-1:0] wr_imag,
	output mpp_pkg::cell_data_t               data
);
	import mpp_pkg::*;

	cell_data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q.bi <= '0;
			data_q.bq <= '0;
			data_q.cr <= first_cell ? COEFF_W'(COEFF_ONE) : '0;
			data_q.ci <= '0;
		end else if (ctl.rotate) begin
			data_q <= prev;
		end else if (ctl.load) begin
			data_q.bi <= prev.bi;
			data_q.bq <= prev.bq;
		end else if (coeff_we) begin
			data_q.cr <= wr_real;
			data_q.ci <= wr_imag;
		end
	end

	assign data = data_q;

endmodule

### rtl/mpp_mac.sv
// ----------------------------------------------------------------------------
// mpp_mac
// Complex multiply-accumulate on the head cell, with output saturation.
// ----------------------------------------------------------------------------
module mpp_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clear,
	input  logic                                  valid,
	input  mpp_pkg::cell_data_t                   head,
	output logic signed [mpp_pkg::SAMPLE_BITS-1:0] y_i,
	output logic signed [mpp_pkg::SAMPLE_BITS-1:0] y_q,
	output logic                                  clip
);
	import mpp_pkg::*;

	logic signed [PROD_W-1:0] p_rr_s1, p_iq_s1, p_rq_s1, p_ii_s1;
	logic                     v_s1;
	logic signed [ACC_W-1:0]  acc_i_q, acc_q_q;
	logic signed [ACC_W-17:0] sh_i, sh_q;
	logic                     clip_i, clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= head.cr * head.bi;
		p_iq_s1 <= head.ci * head.bq;
		p_rq_s1 <= head.cr * head.bq;
		p_ii_s1 <= head.ci * head.bi;
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (v_s1) begin
			acc_i_q <= acc_i_q + ACC_W'(p_rr_s1) - ACC_W'(p_iq_s1);
			acc_q_q <= acc_q_q + ACC_W'(p_rq_s1) + ACC_W'(p_ii_s1);
		end
	end

	assign sh_i = acc_i_q[ACC_W-1:16];
	assign sh_q = acc_q_q[ACC_W-1:16];

	always_comb begin
		clip_i = 1'b1;
		clip_q = 1'b1;
		if (sh_i > OUT_MAX)      y_i = SAMPLE_BITS'(OUT_MAX);
		else if (sh_i < OUT_MIN) y_i = SAMPLE_BITS'(OUT_MIN);
		else begin
			y_i    = sh_i[SAMPLE_BITS-1:0];
			clip_i = 1'b0;
		end
		if (sh_q > OUT_MAX)      y_q = SAMPLE_BITS'(OUT_MAX);
		else if (sh_q < OUT_MIN) y_q = SAMPLE_BITS'(OUT_MIN);
		else begin
			y_q    = sh_q[SAMPLE_BITS-1:0];
			clip_q = 1'b0;
		end
		clip = clip_i | clip_q;
	end

endmodule

### rtl/memory_polynomial_predistorter_top.sv
// A coefficient write goes from acceptance straight to the result state; a sample
// first passes through the envelope, basis, load, sum and drain states.
// One transaction at a time: the cell chain rotates past the single complex MAC,
// and in_stall stays high until the sequencer is back in idle.
// A finished result waits in the output register. Reset: arst_n clears the delay line,
// loads coefficient (0,0) with 1.0 and the limit with 2.0; no clearing pass.
// ----------------------------------------------------------------------------
// memory_polynomial_predistorter_top
// Memory polynomial predistorter built on a rotating chain of cells.
// ----------------------------------------------------------------------------
module memory_polynomial_predistorter_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   operation,
	input  logic signed [mpp_pkg::SAMPLE_BITS-1:0] sample_i,
	input  logic signed [mpp_pkg::SAMPLE_BITS-1:0] sample_q,
	input  logic [3:0]                             coeff_tap,
	input  logic [2:0]                             coeff_power,
	input  logic signed [mpp_pkg::COEFF_W-1:0]     coeff_real,
	input  logic signed [mpp_pkg::COEFF_W-1:0]     coeff_imag,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [mpp_pkg::SAMPLE_BITS-1:0] pre_i,
	output logic signed [mpp_pkg::SAMPLE_BITS-1:0] pre_q,
	output logic                                   limited,
	input  logic                                   cfg_we,
	input  logic [mpp_pkg::LIMIT_W-1:0]            cfg_wdata
);
	import mpp_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [LIMIT_W-1:0] limit_q;
	logic accept;

	logic signed [BASIS_W-1:0] bas_i_q [POWERS];
	logic signed [BASIS_W-1:0] bas_q_q [POWERS];
	logic [ENV_W-1:0]          env_q;
	logic [PWR_W-1:0]          pwr;
	logic signed [BASIS_W+ENV_W:0] prod_i, prod_q;

	logic is_sample_q;
	logic signed [SAMPLE_BITS-1:0] res_i_q, res_q_q;
	logic res_lim_q;
	logic signed [SAMPLE_BITS-1:0] out_i_q, out_q_q;
	logic out_lim_q, out_valid_q;

	cell_ctl_t  ctl;
	cell_data_t chain [CELLS];
	cell_data_t feed;
	logic       mac_clear, mac_valid;
	logic signed [SAMPLE_BITS-1:0] y_i, y_q;
	logic       y_clip;

	// coefficient clamp
	logic signed [31:0] bound, re_c, im_c;
	logic               hit_re, hit_im, wr_ok, wr_en;
	logic [IDX_W-1:0]   widx;

	always_comb begin
		bound  = 32'(limit_q) <<< coeff_power;
		re_c   = 32'(coeff_real);
		im_c   = 32'(coeff_imag);
		hit_re = 1'b0;
		hit_im = 1'b0;
		if (re_c > bound) begin
			re_c   = bound - COEFF_EPS;
			hit_re = 1'b1;
		end
		if (re_c < -bound) begin
			re_c   = -bound + COEFF_EPS;
			hit_re = 1'b1;
		end
		if (im_c > bound) begin
			im_c   = bound - COEFF_EPS;
			hit_im = 1'b1;
		end
		if (im_c < -bound) begin
			im_c   = -bound + COEFF_EPS;
			hit_im = 1'b1;
		end
		wr_ok = (32'(coeff_tap) <= MEMORY_DEPTH) && (32'(coeff_power) <= ORDER);
		widx  = IDX_W'(32'(coeff_tap) * POWERS + 32'(coeff_power));
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign wr_en    = accept && (operation == OP_COEFF) && wr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ctl       = '0;
		mac_clear = 1'b0;
		mac_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (operation == OP_COEFF) ? ST_FIN : ST_ENV;
				end
			end
			ST_ENV: begin
				cnt_d   = CNT_W'(1);
				state_d = (ORDER > 0) ? ST_BASIS : ST_LOAD;
				if (ORDER == 0) cnt_d = '0;
			end
			ST_BASIS: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ORDER)) begin
					cnt_d   = '0;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(POWERS - 1)) begin
					cnt_d     = '0;
					mac_clear = 1'b1;
					state_d   = ST_SUM;
				end
			end
			ST_SUM: begin
				ctl.rotate = 1'b1;
				mac_valid  = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// envelope and basis terms
	function automatic logic [PWR_W-1:0] sample_i_sq();
		logic signed [PWR_W-1:0] a, b;
		a = PWR_W'($signed(bas_i_q[0][SAMPLE_BITS-1:0])) *
			PWR_W'($signed(bas_i_q[0][SAMPLE_BITS-1:0]));
		b = PWR_W'($signed(bas_q_q[0][SAMPLE_BITS-1:0])) *
			PWR_W'($signed(bas_q_q[0][SAMPLE_BITS-1:0]));
		return a + b;
	endfunction

	assign pwr = PWR_W'(sample_i_sq()) ;

	assign prod_i = bas_i_q[PIDX_W'(cnt_q - 1'b1)] * $signed({1'b0, env_q});
	assign prod_q = bas_q_q[PIDX_W'(cnt_q - 1'b1)] * $signed({1'b0, env_q});

	always_ff @(posedge clk) begin
		if (accept && operation == OP_SAMPLE) begin
			bas_i_q[0] <= BASIS_W'(sample_i);
			bas_q_q[0] <= BASIS_W'(sample_q);
		end
		if (state_q == ST_ENV) begin
			env_q <= ENV_W'((pwr >> ENV_SHR) << ENV_SHL);
		end
		if (state_q == ST_BASIS) begin
			bas_i_q[PIDX_W'(cnt_q)] <= prod_i[16 +: BASIS_W];
			bas_q_q[PIDX_W'(cnt_q)] <= prod_q[16 +: BASIS_W];
		end
	end

	// cell chain; highest power enters first so row 0 ends in power order
	always_comb begin
		feed    = chain[CELLS-1];
		if (state_q == ST_LOAD) begin
			feed.bi = bas_i_q[PIDX_W'(CNT_W'(POWERS - 1) - cnt_q)];
			feed.bq = bas_q_q[PIDX_W'(CNT_W'(POWERS - 1) - cnt_q)];
		end
	end

	genvar g;
	generate
		for (g = 0; g < CELLS; g++) begin : g_cell
			mpp_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.first_cell (g == 0),
				.ctl        (ctl),
				.prev       ((g == 0) ? feed : chain[(g == 0) ? 0 : g - 1]),
				.coeff_we   (wr_en && (widx == IDX_W'(g))),
				.wr_real    (re_c[COEFF_W-1:0]),
				.wr_imag    (im_c[COEFF_W-1:0]),
				.data       (chain[g])
			);
		end
	endgenerate

	mpp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (mac_clear),
		.valid  (mac_valid),
		.head   (chain[CELLS-1]),
		.y_i    (y_i),
		.y_q    (y_q),
		.clip   (y_clip)
	);

	// result staging and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			is_sample_q <= (operation == OP_SAMPLE);
			res_i_q     <= '0;
			res_q_q     <= '0;
			res_lim_q   <= wr_ok && (hit_re || hit_im);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
			out_i_q   <= is_sample_q ? y_i : res_i_q;
			out_q_q   <= is_sample_q ? y_q : res_q_q;
			out_lim_q <= is_sample_q ? y_clip : res_lim_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pre_i     = out_i_q;
	assign pre_q     = out_q_q;
	assign limited   = out_lim_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("result dropped under stall");
	a_sum_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (cnt_q < CNT_W'(CELLS)))
		else $error("rotation count overran chain");
	a_fin_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && cnt_q == CNT_W'(CELLS - 1)) |=> (state_q == ST_DRAIN))
		else $error("sum phase did not close");

endmodule
